FILE: rtl/nptt_pkg.sv
// Shared types, constants and helpers for the NAPT port translation table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package nptt_pkg;

   localparam int NAT_ENTRIES = 64;
   localparam int IDX_W = $clog2(NAT_ENTRIES);
   localparam int ACT_W = $clog2(NAT_ENTRIES + 1);
   localparam int TRY_W = $clog2(NAT_ENTRIES + 1);

   localparam logic [7:0]  PROTO_TCP    = 8'd6;
   localparam logic [7:0]  PROTO_UDP    = 8'd17;
   localparam logic [15:0] MIN_LENGTH   = 16'd28;
   localparam logic [15:0] TIMEOUT_RST  = 16'd300;
   localparam logic [15:0] PORT_BASE_RST = 16'd32768;
   localparam logic [15:0] PORT_TOP_RST = 16'd65535;

   typedef enum logic [1:0] {
      KIND_OUTBOUND = 2'd0,
      KIND_INBOUND  = 2'd1,
      KIND_TICK     = 2'd2,
      KIND_SWEEP    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      VERDICT_DONE        = 2'd0,
      VERDICT_NOT_HANDLED = 2'd1,
      VERDICT_NO_ENTRY    = 2'd2,
      VERDICT_FULL        = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      CSUM_NONE = 2'd0,
      CSUM_TCP  = 2'd1,
      CSUM_UDP  = 2'd2
   } csum_type;

   typedef enum logic [1:0] {
      CSR_IDLE_TIMEOUT = 2'd0,
      CSR_PORT_BASE    = 2'd1,
      CSR_PORT_TOP     = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_DECIDE,
      ST_ALLOC,
      ST_SWEEP,
      ST_DONE
   } state_type;

   // Classified item as it travels from the front to the back
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  protocol;
      logic [31:0] source_address;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic        handled;
      csum_type    code;
   } item_type;

   function automatic logic [6:0] sat7(input logic [ACT_W-1:0] v);
      logic [6:0] r;
      if (ACT_W > 7 && 32'(v) > 32'd127) r = 7'd127;
      else r = 7'(v);
      return r;
   endfunction

   // Lowest set bit of a vector
   function automatic logic [IDX_W-1:0] first_set(input logic [NAT_ENTRIES-1:0] v);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int i = NAT_ENTRIES - 1; i >= 0; i--) begin
         if (v[i]) r = IDX_W'(i);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/nptt_front.sv
// Front end: accepts request transfers and classifies them for the back end.
// Depends on nptt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nptt_front import nptt_pkg::*; (
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_protocol,
   input  wire logic [15:0] req_captured_length,
   input  wire logic [31:0] req_source_address,
   input  wire logic [15:0] req_src_port,
   input  wire logic [15:0] req_dst_port,
   input  wire logic        q_full,
   output logic             q_push,
   output item_type         q_item
);

   logic is_tcp;
   logic is_udp;

   assign is_tcp = (req_protocol == PROTO_TCP);
   assign is_udp = (req_protocol == PROTO_UDP);

   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full;

   always_comb begin
      q_item.kind           = kind_type'(req_kind);
      q_item.protocol       = req_protocol;
      q_item.source_address = req_source_address;
      q_item.src_port       = req_src_port;
      q_item.dst_port       = req_dst_port;
      q_item.handled        = (is_tcp | is_udp) & (req_captured_length >= MIN_LENGTH);
      q_item.code           = is_tcp ? CSUM_TCP : CSUM_UDP;
   end

endmodule
`default_nettype wire

FILE: rtl/nptt_queue.sv
// Two-entry queue of classified items between the front and back ends.
// Depends on nptt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nptt_queue import nptt_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   input  wire logic     pop,
   output logic          full,
   output logic          head_valid,
   output item_type      head_item
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule
`default_nettype wire

FILE: rtl/nptt_back.sv
// Back end: the translation table, its sequencer and the result register.
// Depends on nptt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nptt_back import nptt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [15:0] idle_timeout,
   input  wire logic [15:0] port_base,
   input  wire logic [15:0] port_top,
   input  wire logic        q_valid,
   input  wire item_type    q_item,
   output logic             q_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_verdict,
   output logic [31:0]      rsp_new_address,
   output logic [15:0]      rsp_new_port,
   output logic [1:0]       rsp_checksum_clear,
   output logic [6:0]       rsp_expired_count,
   output logic [6:0]       rsp_active_entries
);

   // table
   logic        valid_ff [NAT_ENTRIES];
   logic [7:0]  proto_ff [NAT_ENTRIES];
   logic [15:0] ext_ff   [NAT_ENTRIES];
   logic [31:0] addr_ff  [NAT_ENTRIES];
   logic [15:0] iport_ff [NAT_ENTRIES];
   logic [31:0] seen_ff  [NAT_ENTRIES];

   state_type        st_ff, st_in;
   item_type         item_ff, item_in;
   logic [NAT_ENTRIES-1:0] out_hit_ff, in_hit_ff, free_ff;
   logic [NAT_ENTRIES-1:0] out_hit, in_hit, free_vec, in_use_vec;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0] sidx_ff, sidx_in;
   logic [15:0]      cand_ff, cand_in;
   logic [TRY_W-1:0] tries_ff, tries_in;
   logic [ACT_W-1:0] nexp_ff, nexp_in;
   logic [ACT_W-1:0] act_ff, act_in;
   logic [15:0]      alloc_port_ff, alloc_port_in;
   logic [31:0]      secs_ff, secs_in;

   verdict_type      r_verdict_ff, r_verdict_in;
   logic [31:0]      r_addr_ff, r_addr_in;
   logic [15:0]      r_port_ff, r_port_in;
   csum_type         r_csum_ff, r_csum_in;
   logic [6:0]       r_exp_ff, r_exp_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_verdict_ff, rsp_verdict_in;
   logic [31:0]      rsp_addr_ff, rsp_addr_in;
   logic [15:0]      rsp_port_ff, rsp_port_in;
   logic [1:0]       rsp_csum_ff, rsp_csum_in;
   logic [6:0]       rsp_exp_ff, rsp_exp_in;
   logic [6:0]       rsp_act_ff, rsp_act_in;

   logic             seen_we, new_we, clr_we;
   logic [IDX_W-1:0] seen_idx;
   logic [IDX_W-1:0] hit_o, hit_i;
   logic [15:0]      top_eff, cand_fix, cand_nxt;
   logic [31:0]      idle;

   assign hit_o = first_set(out_hit_ff);
   assign hit_i = first_set(in_hit_ff);

   // Inverted range collapses to the base port alone
   assign top_eff  = (port_top < port_base) ? port_base : port_top;
   assign cand_fix = (cand_ff < port_base || cand_ff > top_eff) ? port_base : cand_ff;
   assign cand_nxt = (cand_fix == top_eff) ? port_base : cand_fix + 16'd1;
   assign idle     = secs_ff - seen_ff[sidx_ff];

   always_comb begin
      for (int i = 0; i < NAT_ENTRIES; i++) begin
         out_hit[i] = valid_ff[i] && proto_ff[i] == item_ff.protocol
                      && addr_ff[i] == item_ff.source_address
                      && iport_ff[i] == item_ff.src_port;
         in_hit[i]  = valid_ff[i] && proto_ff[i] == item_ff.protocol
                      && ext_ff[i] == item_ff.dst_port;
         free_vec[i] = ~valid_ff[i];
         in_use_vec[i] = valid_ff[i] && proto_ff[i] == item_ff.protocol
                         && ext_ff[i] == cand_fix;
      end
   end

   always_comb begin
      st_in        = st_ff;
      item_in      = item_ff;
      slot_in      = slot_ff;
      sidx_in      = sidx_ff;
      cand_in      = cand_ff;
      tries_in     = tries_ff;
      nexp_in      = nexp_ff;
      act_in       = act_ff;
      alloc_port_in = alloc_port_ff;
      secs_in      = secs_ff;
      r_verdict_in = r_verdict_ff;
      r_addr_in    = r_addr_ff;
      r_port_in    = r_port_ff;
      r_csum_in    = r_csum_ff;
      r_exp_in     = r_exp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_port_in  = rsp_port_ff;
      rsp_csum_in  = rsp_csum_ff;
      rsp_exp_in   = rsp_exp_ff;
      rsp_act_in   = rsp_act_ff;
      q_pop        = 1'b0;
      seen_we      = 1'b0;
      seen_idx     = hit_o;
      new_we       = 1'b0;
      clr_we       = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop        = 1'b1;
               item_in      = q_item;
               r_verdict_in = VERDICT_DONE;
               r_addr_in    = '0;
               r_port_in    = '0;
               r_csum_in    = CSUM_NONE;
               r_exp_in     = '0;
               st_in        = ST_MATCH;
            end
         end
         ST_MATCH: begin
            st_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            st_in = ST_DONE;
            case (item_ff.kind)
               KIND_OUTBOUND: begin
                  if (!item_ff.handled) begin
                     r_verdict_in = VERDICT_NOT_HANDLED;
                  end else if (|out_hit_ff) begin
                     seen_we   = 1'b1;
                     seen_idx  = hit_o;
                     r_port_in = ext_ff[hit_o];
                     r_csum_in = item_ff.code;
                  end else if (!(|free_ff)) begin
                     r_verdict_in = VERDICT_FULL;
                  end else begin
                     slot_in  = first_set(free_ff);
                     cand_in  = alloc_port_ff;
                     tries_in = '0;
                     st_in    = ST_ALLOC;
                  end
               end
               KIND_INBOUND: begin
                  if (!item_ff.handled) begin
                     r_verdict_in = VERDICT_NOT_HANDLED;
                  end else if (|in_hit_ff) begin
                     seen_we   = 1'b1;
                     seen_idx  = hit_i;
                     r_addr_in = addr_ff[hit_i];
                     r_port_in = iport_ff[hit_i];
                     r_csum_in = item_ff.code;
                  end else begin
                     r_verdict_in = VERDICT_NO_ENTRY;
                  end
               end
               KIND_TICK: begin
                  secs_in = secs_ff + 32'd1;
               end
               default: begin
                  sidx_in = '0;
                  nexp_in = '0;
                  st_in   = ST_SWEEP;
               end
            endcase
         end
         ST_ALLOC: begin
            // one candidate port per cycle
            if (!(|in_use_vec)) begin
               new_we       = 1'b1;
               alloc_port_in = cand_nxt;
               r_port_in    = cand_fix;
               r_csum_in    = item_ff.code;
               act_in       = act_ff + ACT_W'(1);
               st_in        = ST_DONE;
            end else if (tries_ff == TRY_W'(NAT_ENTRIES)) begin
               r_verdict_in = VERDICT_FULL;
               st_in        = ST_DONE;
            end else begin
               cand_in  = cand_nxt;
               tries_in = tries_ff + TRY_W'(1);
            end
         end
         ST_SWEEP: begin
            if (valid_ff[sidx_ff] && idle > {16'd0, idle_timeout}) begin
               clr_we  = 1'b1;
               nexp_in = nexp_ff + ACT_W'(1);
               act_in  = act_ff - ACT_W'(1);
            end
            sidx_in = sidx_ff + IDX_W'(1);
            if (sidx_ff == IDX_W'(NAT_ENTRIES - 1)) begin
               r_exp_in = sat7(nexp_in);
               st_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the result register is free
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = r_verdict_ff;
               rsp_addr_in    = r_addr_ff;
               rsp_port_in    = r_port_ff;
               rsp_csum_in    = r_csum_ff;
               rsp_exp_in     = r_exp_ff;
               rsp_act_in     = sat7(act_ff);
               st_in          = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         act_ff       <= '0;
         alloc_port_ff <= PORT_BASE_RST;
         secs_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NAT_ENTRIES; i++) valid_ff[i] <= 1'b0;
      end else begin
         st_ff        <= st_in;
         act_ff       <= act_in;
         alloc_port_ff <= alloc_port_in;
         secs_ff      <= secs_in;
         rsp_valid_ff <= rsp_valid_in;
         if (new_we) valid_ff[slot_ff] <= 1'b1;
         if (clr_we) valid_ff[sidx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      slot_ff      <= slot_in;
      sidx_ff      <= sidx_in;
      cand_ff      <= cand_in;
      tries_ff     <= tries_in;
      nexp_ff      <= nexp_in;
      r_verdict_ff <= r_verdict_in;
      r_addr_ff    <= r_addr_in;
      r_port_ff    <= r_port_in;
      r_csum_ff    <= r_csum_in;
      r_exp_ff     <= r_exp_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_port_ff  <= rsp_port_in;
      rsp_csum_ff  <= rsp_csum_in;
      rsp_exp_ff   <= rsp_exp_in;
      rsp_act_ff   <= rsp_act_in;
      if (st_ff == ST_MATCH) begin
         out_hit_ff <= out_hit;
         in_hit_ff  <= in_hit;
         free_ff    <= free_vec;
      end
      if (new_we) begin
         proto_ff[slot_ff] <= item_ff.protocol;
         ext_ff[slot_ff]   <= cand_fix;
         addr_ff[slot_ff]  <= item_ff.source_address;
         iport_ff[slot_ff] <= item_ff.src_port;
         seen_ff[slot_ff]  <= secs_ff;
      end else if (seen_we) begin
         seen_ff[seen_idx] <= secs_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict        = rsp_verdict_ff;
   assign rsp_new_address    = rsp_addr_ff;
   assign rsp_new_port       = rsp_port_ff;
   assign rsp_checksum_clear = rsp_csum_ff;
   assign rsp_expired_count  = rsp_exp_ff;
   assign rsp_active_entries = rsp_act_ff;

   a_act_bound: assert property (@(posedge clock) disable iff (reset)
      32'(act_ff) <= NAT_ENTRIES)
      else $error("active count above table size");

   a_tries_bound: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_ALLOC |-> 32'(tries_ff) <= NAT_ENTRIES)
      else $error("port search ran past its limit");

   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> st_ff == ST_MATCH)
      else $error("popped item not started");

   a_alloc_free: assert property (@(posedge clock) disable iff (reset)
      new_we |-> !valid_ff[slot_ff])
      else $error("allocation over a valid entry");

endmodule
`default_nettype wire

FILE: rtl/nat_port_translation_table_core.sv
// Top level of the NAPT port translation table: front end, queue, back end.
// Depends on nptt_pkg, nptt_front, nptt_queue and nptt_back.
//
// One result per request. Ticks, lookups, hits and untranslated packets pass
// from the queue head through the match, decide and done states to the result
// register; a miss then tries one port candidate a cycle, 1 to 65 of them; a
// sweep walks the table one entry a cycle. The next item starts once the
// result register is loaded; while a result is stalled the back end holds, and
// the front end keeps taking requests into a two-entry queue, after which the
// input stalls. Write the registers only while no transfer is in flight.
`timescale 1ns / 1ps
`default_nettype none
module nat_port_translation_table_core import nptt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_protocol,
   input  wire logic [15:0] req_captured_length,
   input  wire logic [31:0] req_source_address,
   input  wire logic [15:0] req_src_port,
   input  wire logic [15:0] req_dst_port,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_verdict,
   output logic [31:0]      rsp_new_address,
   output logic [15:0]      rsp_new_port,
   output logic [1:0]       rsp_checksum_clear,
   output logic [6:0]       rsp_expired_count,
   output logic [6:0]       rsp_active_entries
);

   logic [15:0] timeout_ff, base_ff, top_ff;
   logic        q_full, q_push, q_pop, q_valid;
   item_type    push_item, head_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RST;
         base_ff    <= PORT_BASE_RST;
         top_ff     <= PORT_TOP_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_IDLE_TIMEOUT: timeout_ff <= csr_wdata;
            CSR_PORT_BASE:    base_ff    <= csr_wdata;
            CSR_PORT_TOP:     top_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   nptt_front u_front (
      .req_valid, .req_stall, .req_kind, .req_protocol,
      .req_captured_length, .req_source_address, .req_src_port, .req_dst_port,
      .q_full, .q_push, .q_item(push_item)
   );

   nptt_queue u_queue (
      .clock, .reset, .push(q_push), .push_item, .pop(q_pop), .full(q_full),
      .head_valid(q_valid), .head_item
   );

   nptt_back u_back (
      .clock, .reset, .idle_timeout(timeout_ff), .port_base(base_ff),
      .port_top(top_ff), .q_valid, .q_item(head_item), .q_pop,
      .rsp_valid, .rsp_stall, .rsp_verdict, .rsp_new_address, .rsp_new_port,
      .rsp_checksum_clear, .rsp_expired_count, .rsp_active_entries
   );

endmodule
`default_nettype wire
